### hw/rtl/xrs_pkg.sv
`default_nettype none

package xrs_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned HalfW   = WordW / 2;
  localparam int unsigned DivCntW = $clog2(WordW);

  localparam logic [WordW-1:0] RESET_STATE = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WordW-1:0] ZERO_SEED   = 64'hA076_1D64_78BD_642F;
  // 2685821657736338717
  localparam logic [WordW-1:0] STAR_MULT   = 64'h2545_F491_4F6C_DD1D;

  localparam int unsigned ShiftA    = 12;
  localparam int unsigned ShiftB    = 25;
  localparam int unsigned ShiftC    = 27;
  localparam int unsigned UnitShift = 11;

  typedef enum logic [1:0] {
    OP_SEED  = 2'd0,
    OP_RAW   = 2'd1,
    OP_RANGE = 2'd2,
    OP_UNIT  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_DIV,
    ST_FIN
  } state_t;

  // Which 32x32 partial product the shared multiplier forms
  typedef enum logic [1:0] {
    MUL_LL,
    MUL_HL,
    MUL_LH
  } mul_sel_t;

  typedef struct packed {
    logic     load_seed;
    logic     load_op;
    logic     advance;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     acc_add;
    logic     div_start;
    logic     div_step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    span_zero;
    logic    out_busy;
  } stat_t;

  function automatic logic [WordW-1:0] fix_zero(input logic [WordW-1:0] v);
    return (v == '0) ? ZERO_SEED : v;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/xrs_if.sv
`default_nettype none

interface xrs_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        opcode;
  logic [xrs_pkg::WordW-1:0]         seed_value;
  logic signed [xrs_pkg::WordW-1:0]  range_min;
  logic signed [xrs_pkg::WordW-1:0]  range_max;

  modport source (output valid, opcode, seed_value, range_min, range_max, input ready);
  modport sink (input valid, opcode, seed_value, range_min, range_max, output ready);
endinterface

interface xrs_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [xrs_pkg::WordW-1:0] draw_value;

  modport source (output valid, draw_value, input ready);
  modport sink (input valid, draw_value, output ready);
endinterface

`default_nettype wire

### hw/rtl/xrs_ctrl.sv
`default_nettype none

module xrs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  input  wire logic [1:0]    req_opcode,
  output logic               req_ready,
  input  wire xrs_pkg::stat_t stat,
  output xrs_pkg::cmd_t      cmd
);
  import xrs_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [DivCntW-1:0]  cnt;
  logic                accept;
  logic                is_seed;
  logic                div_last;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign is_seed   = (opcode_t'(req_opcode) == OP_SEED);
  assign div_last  = (cnt == DivCntW'(WordW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_MUL3) begin
        cnt <= '0;
      end else if (state == ST_DIV) begin
        cnt <= cnt + DivCntW'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && !is_seed) state_next = ST_SHIFT;
      ST_SHIFT: state_next = ST_MUL0;
      ST_MUL0:  state_next = ST_MUL1;
      ST_MUL1:  state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_MUL3;
      ST_MUL3: begin
        if (stat.op == OP_RANGE && !stat.span_zero) state_next = ST_DIV;
        else state_next = ST_FIN;
      end
      ST_DIV:   if (div_last) state_next = ST_FIN;
      ST_FIN:   if (!stat.out_busy) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = MUL_LL;
    cmd.load_seed = accept && is_seed;
    cmd.load_op   = accept && !is_seed;
    unique case (state)
      ST_SHIFT: cmd.advance = 1'b1;
      ST_MUL0:  cmd.mul_sel = MUL_LL;
      ST_MUL1: begin
        cmd.mul_sel  = MUL_HL;
        cmd.acc_load = 1'b1;
      end
      ST_MUL2: begin
        cmd.mul_sel = MUL_LH;
        cmd.acc_add = 1'b1;
      end
      ST_MUL3: begin
        cmd.acc_add   = 1'b1;
        cmd.div_start = 1'b1;
      end
      ST_DIV:   cmd.div_step = 1'b1;
      ST_FIN:   cmd.out_load = !stat.out_busy;
      default: ;
    endcase
  end

  a_accept_draw: assert property (@(posedge clk) disable iff (rst)
    cmd.load_op |=> state == ST_SHIFT)
    else $error("draw accepted but sequencer did not start");

  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL3 && stat.op == OP_RANGE && !stat.span_zero)
      |=> (state == ST_DIV && cnt == '0))
    else $error("division not started with a cleared step count");

  a_seed_stays_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_seed |=> state == ST_IDLE)
    else $error("seed load left the idle state");

endmodule

`default_nettype wire

### hw/rtl/xrs_dp.sv
`default_nettype none

module xrs_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire xrs_pkg::cmd_t                     cmd,
  output xrs_pkg::stat_t                         stat,
  input  wire logic [1:0]                        opcode,
  input  wire logic [xrs_pkg::WordW-1:0]         seed_value,
  input  wire logic signed [xrs_pkg::WordW-1:0]  range_min,
  input  wire logic signed [xrs_pkg::WordW-1:0]  range_max,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_ready,
  output logic [xrs_pkg::WordW-1:0]              draw_value
);
  import xrs_pkg::*;

  logic [WordW-1:0] rand_state;
  logic [WordW-1:0] x_a;
  logic [WordW-1:0] x_b;
  logic [WordW-1:0] x_c;
  opcode_t          op;
  logic [WordW-1:0] lo;
  logic [WordW-1:0] span;
  logic             swap;
  logic [WordW-1:0] lo_next;
  logic [WordW-1:0] hi_next;
  logic [HalfW-1:0] mul_a;
  logic [HalfW-1:0] mul_b;
  logic [WordW-1:0] prod;
  logic [WordW-1:0] acc;
  logic [WordW-1:0] rem;
  logic [WordW:0]   rem_sh;
  logic [WordW:0]   rem_sub;
  logic             span_zero;
  logic [WordW-1:0] result;

  // xorshift of the current state; a nonzero word never maps to zero
  assign x_a = fix_zero(rand_state) ^ (fix_zero(rand_state) >> ShiftA);
  assign x_b = x_a ^ (x_a << ShiftB);
  assign x_c = x_b ^ (x_b >> ShiftC);

  assign swap    = (range_max < range_min);
  assign lo_next = swap ? range_max : range_min;
  assign hi_next = swap ? range_min : range_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      rand_state <= RESET_STATE;
    end else if (cmd.load_seed) begin
      rand_state <= fix_zero(seed_value);
    end else if (cmd.advance) begin
      rand_state <= fix_zero(x_c);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op   <= opcode_t'(opcode);
      lo   <= lo_next;
      span <= hi_next - lo_next + WordW'(1);
    end
  end

  // Shared 32x32 multiplier: low 64 bits of state times the star constant
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_LL: begin
        mul_a = rand_state[HalfW-1:0];
        mul_b = STAR_MULT[HalfW-1:0];
      end
      MUL_HL: begin
        mul_a = rand_state[WordW-1:HalfW];
        mul_b = STAR_MULT[HalfW-1:0];
      end
      MUL_LH: begin
        mul_a = rand_state[HalfW-1:0];
        mul_b = STAR_MULT[WordW-1:HalfW];
      end
      default: begin
        mul_a = rand_state[HalfW-1:0];
        mul_b = STAR_MULT[HalfW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= WordW'(mul_a) * WordW'(mul_b);
  end

  // Restoring division: the draw shifts out of acc one bit per step
  assign rem_sh  = {rem, acc[WordW-1]};
  assign rem_sub = rem_sh - {1'b0, span};

  always_ff @(posedge clk) begin
    if (cmd.acc_load) begin
      acc <= prod;
    end else if (cmd.acc_add) begin
      acc[WordW-1:HalfW] <= acc[WordW-1:HalfW] + prod[HalfW-1:0];
    end else if (cmd.div_step) begin
      acc <= acc << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_sub[WordW] ? rem_sh[WordW-1:0] : rem_sub[WordW-1:0];
    end
  end

  assign span_zero = (span == '0);

  always_comb begin
    unique case (op)
      OP_RANGE: result = span_zero ? acc : lo + rem;
      OP_UNIT:  result = acc >> UnitShift;
      default:  result = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      draw_value <= result;
    end
  end

  assign stat.op        = op;
  assign stat.span_zero = span_zero;
  assign stat.out_busy  = rsp_valid && !rsp_ready;

  a_state_nonzero: assert property (@(posedge clk) disable iff (rst)
    rand_state != '0)
    else $error("generator state reached zero");

  a_rem_below_span: assert property (@(posedge clk) disable iff (rst)
    ($past(cmd.div_step) && !span_zero) |-> rem < span)
    else $error("remainder not below span after a division step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_valid || rsp_ready))
    else $error("output word overwritten before it was taken");

endmodule

`default_nettype wire

### hw/rtl/xorshift64star_random_source.sv
// xorshift64* random source. Each request word carries an opcode: seed loads
// the 64-bit state (a zero seed becomes a fixed nonzero constant) and returns
// nothing; raw returns the next xorshift64* draw; range returns a draw mapped
// into the inclusive signed interval [range_min, range_max] (bounds swapped if
// reversed, raw draw if the interval covers all 64-bit values); unit returns
// the top 53 bits of a draw as a 0.53 fraction in bits 52..0. One request is
// in flight at a time. A seed loads the state and leaves the block idle and ready.
// A raw or unit draw steps from acceptance to the result word through the
// shift-xor update, the 64-bit multiply built from one shared 32x32
// multiplier, and the load of the output register. A ranged draw adds the
// remainder division over all 64 draw bits, one quotient bit per cycle,
// skipped when the interval is full. The next request is taken on the cycle
// after the result word loads. The output register lets a new request be
// accepted while the last result word still waits for the consumer; a finished
// draw holds until that word is taken.
`default_nettype none

module xorshift64star_random_source (
  input  wire logic clk,
  input  wire logic rst,
  xrs_req_if.sink   req,
  xrs_rsp_if.source rsp
);
  import xrs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: accepts requests, steps through shift, multiply, divide, output
  xrs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_opcode (req.opcode),
    .req_ready  (req.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath: state word, multiplier, divider and output register
  xrs_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .opcode     (req.opcode),
    .seed_value (req.seed_value),
    .range_min  (req.range_min),
    .range_max  (req.range_max),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .draw_value (rsp.draw_value)
  );

endmodule

`default_nettype wire

### dv/tb_xorshift64star_random_source.sv
`timescale 1ns / 1ps

module tb_xorshift64star_random_source;
  import xrs_pkg::*;

  // Signed extremes and the all-ones pattern, used by the directed rows
  localparam logic [63:0] S64_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] S64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam int DIR_ROWS    = 25;
  localparam int PHASE_WORDS = 525;
  // Start the long consumer hold-off this many words into the first phase
  localparam int HOLD_AT     = 120;
  localparam int HOLD_CYCLES = 400;
  // Tail wait before the verdict, longer than a ranged draw
  localparam int TAIL_CYCLES = 90;
  // No word moves on either side for this long: the block is hung
  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  xrs_req_if req_ch ();
  xrs_rsp_if rsp_ch ();

  xorshift64star_random_source dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // One directed stimulus row. Where has_want is set the expected draw is
  // typed in (a range collapsed to one value); otherwise the predictor decides.
  typedef struct {
    opcode_t     op;
    logic [63:0] seed;
    logic [63:0] bound_a;
    logic [63:0] bound_b;
    bit          has_want;
    logic [63:0] want;
  } dir_row_t;

  dir_row_t directed_rows [DIR_ROWS] = '{
    // first draw straight out of reset, then a unit fraction of the next draw
    '{OP_RAW,   64'h0,    64'h0,            64'h0,            1'b0, 64'h0},
    '{OP_UNIT,  64'h0,    64'h0,            64'h0,            1'b0, 64'h0},
    // a one-value range returns that value but still advances the state
    '{OP_RANGE, 64'h0,    64'd5,            64'd5,            1'b1, 64'd5},
    // zero seed swaps in the fixed nonzero constant
    '{OP_SEED,  64'h0,    64'h0,            64'h0,            1'b0, 64'h0},
    '{OP_RAW,   64'h0,    64'h0,            64'h0,            1'b0, 64'h0},
    '{OP_SEED,  ALL_ONES, 64'h0,            64'h0,            1'b0, 64'h0},
    '{OP_UNIT,  64'h0,    64'h0,            64'h0,            1'b0, 64'h0},
    // full signed range: span wraps to zero, raw draw comes back
    '{OP_RANGE, 64'h0,    S64_MIN,          S64_MAX,          1'b0, 64'h0},
    '{OP_RANGE, 64'h0,    S64_MAX,          S64_MIN,          1'b0, 64'h0},
    // reversed small bounds get swapped: [-10, 10]
    '{OP_RANGE, 64'h0,    64'd10,           64'hFFFF_FFFF_FFFF_FFF6, 1'b0, 64'h0},
    '{OP_RANGE, 64'h0,    S64_MAX,          S64_MAX,          1'b1, S64_MAX},
    '{OP_RANGE, 64'h0,    S64_MIN,          S64_MIN,          1'b1, S64_MIN},
    '{OP_RANGE, 64'h0,    S64_MIN,          64'h0,            1'b0, 64'h0},
    '{OP_RANGE, 64'h0,    ALL_ONES,         S64_MAX,          1'b0, 64'h0},
    // span of all ones: the largest divisor short of the wrap
    '{OP_RANGE, 64'h0,    S64_MIN + 64'd1,  S64_MAX,          1'b0, 64'h0},
    '{OP_RANGE, 64'h0,    64'h0,            64'd1,            1'b0, 64'h0},
    '{OP_SEED,  64'd1,    64'h0,            64'h0,            1'b0, 64'h0},
    '{OP_RAW,   64'h0,    64'h0,            64'h0,            1'b0, 64'h0},
    '{OP_SEED,  S64_MIN,  64'h0,            64'h0,            1'b0, 64'h0},
    '{OP_UNIT,  64'h0,    64'h0,            64'h0,            1'b0, 64'h0},
    // unused fields loaded with ones must not matter
    '{OP_RAW,   ALL_ONES, ALL_ONES,         ALL_ONES,         1'b0, 64'h0},
    '{OP_UNIT,  ALL_ONES, S64_MIN,          S64_MAX,          1'b0, 64'h0},
    '{OP_RANGE, ALL_ONES, ALL_ONES,         ALL_ONES,         1'b1, ALL_ONES},
    '{OP_SEED,  64'h0,    ALL_ONES,         ALL_ONES,         1'b0, 64'h0},
    '{OP_RANGE, 64'h0,    64'h0,            64'h0,            1'b1, 64'h0}
  };

  // Predictor state and the draws still owed by the block
  logic [63:0] rng_state;
  logic [63:0] expected_draws [$];
  int unsigned mismatches = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_pending  = 1'b0;
  int unsigned quiet_cycles  = 0;

  // Advance the xorshift64* state once and return the scrambled draw.
  function automatic logic [63:0] advance_rng();
    logic [63:0] x;
    x = (rng_state == '0) ? ZERO_SEED : rng_state;
    x ^= x >> ShiftA;
    x ^= x << ShiftB;
    x ^= x >> ShiftC;
    rng_state = (x == '0) ? ZERO_SEED : x;
    return x * STAR_MULT;
  endfunction

  // Apply one request word to the predictor; return 1 when it yields a draw.
  function automatic bit predict_word(input opcode_t op, input logic [63:0] seed,
                                      input logic signed [63:0] bound_a,
                                      input logic signed [63:0] bound_b,
                                      output logic [63:0] draw);
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    logic [63:0]        span;
    logic [63:0]        raw;
    draw = '0;
    case (op)
      OP_SEED: begin
        rng_state = (seed == '0) ? ZERO_SEED : seed;
        return 1'b0;
      end
      OP_RAW: begin
        draw = advance_rng();
      end
      OP_RANGE: begin
        lo = bound_a;
        hi = bound_b;
        if (hi < lo) begin
          lo = bound_b;
          hi = bound_a;
        end
        span = hi - lo + 64'd1;
        raw  = advance_rng();
        if (span == '0) begin
          draw = raw;
        end else begin
          draw = lo + (raw % span);
        end
      end
      default: begin
        draw = advance_rng() >> UnitShift;
      end
    endcase
    return 1'b1;
  endfunction

  // Pick a range bound: extremes, values close to them, small signed values,
  // and full-width random patterns of varied magnitude.
  function automatic logic [63:0] pick_bound();
    int s;
    s = $urandom_range(2000) - 1000;
    case ($urandom_range(7))
      0:       return S64_MIN;
      1:       return S64_MAX;
      2, 3:    return {$urandom, $urandom};
      4:       return {{32{s[31]}}, s};
      5:       return S64_MIN + 64'($urandom_range(1000));
      6:       return S64_MAX - 64'($urandom_range(1000));
      default: return {$urandom, $urandom} >> $urandom_range(63);
    endcase
  endfunction

  // Offer one request word, idling first at the current sender rate. Returns
  // at the falling edge after acceptance with valid still high, so the next
  // word can follow back to back.
  task automatic send_word(input opcode_t op, input logic [63:0] seed,
                           input logic [63:0] bound_a, input logic [63:0] bound_b,
                           input bit has_want, input logic [63:0] want);
    logic [63:0] draw;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= op;
    req_ch.seed_value <= seed;
    req_ch.range_min  <= bound_a;
    req_ch.range_max  <= bound_b;
    do @(posedge clk); while (!req_ch.ready);
    if (predict_word(op, seed, bound_a, bound_b, draw)) begin
      expected_draws.push_back(has_want ? want : draw);
    end
    @(negedge clk);
  endtask

  // Drop valid and hold the sender until every owed draw has come back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (expected_draws.size() != 0);
  endtask

  // Consumer side: random back-pressure at the current rate, or one long
  // hold-off when asked, so the output register and the core both fill up.
  initial begin : draw_sink
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare every accepted draw with the oldest one owed.
  always @(posedge clk) begin : check_draws
    logic [63:0] want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_draws.size() == 0) begin
        $display("%0t: unexpected draw: expected none, got %h", $time, rsp_ch.draw_value);
        mismatches++;
      end else begin
        want = expected_draws.pop_front();
        if (rsp_ch.draw_value !== want) begin
          $display("%0t: draw mismatch: expected %h, got %h", $time, want,
                   rsp_ch.draw_value);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : stimulus
    opcode_t     op;
    logic [63:0] seed;
    logic [63:0] bound_a;
    logic [63:0] bound_b;
    int unsigned pick;
    int          delta;

    rng_state         = RESET_STATE;
    req_ch.valid      = 1'b0;
    req_ch.opcode     = OP_SEED;
    req_ch.seed_value = '0;
    req_ch.range_min  = '0;
    req_ch.range_max  = '0;

    // Hold reset, then release it on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows under the first idling mix
    send_idle_pct = 17;
    recv_idle_pct = 50;
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].op, directed_rows[i].seed, directed_rows[i].bound_a,
                directed_rows[i].bound_b, directed_rows[i].has_want, directed_rows[i].want);
    end
    wait_drained();

    // Random words in three idling phases: sender light / receiver heavy,
    // then swapped, then both sides at full rate. Drain between phases.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 50 : 0;
      recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 17 : 0;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (phase == 0 && n == HOLD_AT) begin
          hold_pending = 1'b1;
        end
        // Mostly draws, with the ranged kind weighted up; seeds now and then
        pick = $urandom_range(99);
        op = (pick < 8) ? OP_SEED : (pick < 28) ? OP_RAW : (pick < 78) ? OP_RANGE : OP_UNIT;
        seed = ($urandom_range(15) == 0) ? 64'h0 : {$urandom, $urandom};
        bound_a = pick_bound();
        // A third of the time keep the bounds close; the order is random
        if ($urandom_range(2) == 0) begin
          delta   = $urandom_range(64) - 32;
          bound_b = bound_a + {{32{delta[31]}}, delta};
        end else begin
          bound_b = pick_bound();
        end
        send_word(op, seed, bound_a, bound_b, 1'b0, 64'h0);
      end
      wait_drained();
    end

    // Let any late or stray draw show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_draws.size() != 0) begin
      $display("%0t: draw mismatch: expected %h, got nothing (%0d owed)", $time,
               expected_draws[0], expected_draws.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### xorshift64star_random_source.f
hw/rtl/xrs_pkg.sv
hw/rtl/xrs_if.sv
hw/rtl/xrs_ctrl.sv
hw/rtl/xrs_dp.sv
hw/rtl/xorshift64star_random_source.sv
dv/tb_xorshift64star_random_source.sv
